// File: design/ngdp_pkg.sv
// Shared constants and helper functions for the next greater digit permutation unit.
`default_nettype none

package ngdp_pkg;

   // Width of the binary operand and the largest digit count it can produce.
   localparam int NUM_BITS           = 31;
   localparam int NUM_DIGITS         = 10;
   localparam int DEFAULT_MAX_DIGITS = 10;

   // Double-dabble steps folded into one register stage.
   localparam int STEPS_PER_STAGE = 8;

   // Digits summed into the low partial word during recombination.
   localparam int LO_DIGITS = 5;

   localparam int RESULT_BITS = 32;
   localparam logic [RESULT_BITS-1:0] INT_MAX    = 32'h7FFF_FFFF;
   localparam logic [RESULT_BITS-1:0] NONE_VALUE = 32'hFFFF_FFFF;

   // Ten to the power n, evaluated at elaboration for weights and limits.
   function automatic logic [63:0] pow10(input int n);
      logic [63:0] r;
      r = 64'd1;
      for (int i = 0; i < n; i++) begin
         r = r * 64'd10;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/ngdp_bcd.sv
// Pipelined binary to BCD conversion, several double-dabble steps per stage.
`default_nettype none

module ngdp_bcd #(
   parameter int DIGITS = ngdp_pkg::NUM_DIGITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [ngdp_pkg::NUM_BITS-1:0] in_number,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [4*DIGITS-1:0]           out_digits,
   output logic                          out_too_long
);
   import ngdp_pkg::*;

   localparam int Stages = (NUM_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
   localparam int DW     = 4 * DIGITS;
   localparam logic [63:0] Limit = pow10(DIGITS);

   logic                v_ff    [Stages];
   logic [DW-1:0]       bcd_ff  [Stages];
   logic [NUM_BITS-1:0] bin_ff  [Stages];
   logic                long_ff [Stages];
   logic [Stages-1:0]   adv;

   for (genvar s = 0; s < Stages; s++) begin : g_stage
      logic [DW-1:0]       bcd_src;
      logic [NUM_BITS-1:0] bin_src;
      logic                v_src;
      logic                long_src;
      logic                adv_next;
      logic [DW-1:0]       bcd_in;
      logic [NUM_BITS-1:0] bin_in;

      if (s == 0) begin : g_first
         assign bcd_src  = '0;
         assign bin_src  = in_number;
         assign v_src    = in_valid;
         // Operands with more digits than the datapath holds are flagged here.
         assign long_src = ({{(64 - NUM_BITS){1'b0}}, in_number} >= Limit);
      end else begin : g_next
         assign bcd_src  = bcd_ff[s-1];
         assign bin_src  = bin_ff[s-1];
         assign v_src    = v_ff[s-1];
         assign long_src = long_ff[s-1];
      end

      if (s == Stages - 1) begin : g_last
         assign adv_next = out_ready;
      end else begin : g_mid
         assign adv_next = adv[s+1];
      end

      assign adv[s] = !v_ff[s] || adv_next;

      always_comb begin : dabble
         logic [DW-1:0]       b;
         logic [NUM_BITS-1:0] r;
         b = bcd_src;
         r = bin_src;
         for (int q = 0; q < STEPS_PER_STAGE; q++) begin
            if (s * STEPS_PER_STAGE + q < NUM_BITS) begin
               for (int j = 0; j < DIGITS; j++) begin
                  if (b[4*j +: 4] >= 4'd5) begin
                     b[4*j +: 4] = b[4*j +: 4] + 4'd3;
                  end
               end
               {b, r} = {b[DW-2:0], r, 1'b0};
            end
         end
         bcd_in = b;
         bin_in = r;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (adv[s]) begin
            v_ff[s] <= v_src;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            bcd_ff[s]  <= bcd_in;
            bin_ff[s]  <= bin_in;
            long_ff[s] <= long_src;
         end
      end
   end

   assign in_ready     = adv[0];
   assign out_valid    = v_ff[Stages-1];
   assign out_digits   = bcd_ff[Stages-1];
   assign out_too_long = long_ff[Stages-1];

endmodule

`default_nettype wire

// File: design/ngdp_permute.sv
// Pivot search and suffix rearrangement on the decimal digits, three stages.
`default_nettype none

module ngdp_permute #(
   parameter int DIGITS = ngdp_pkg::NUM_DIGITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [4*DIGITS-1:0] in_digits,
   input  logic                in_too_long,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [4*DIGITS-1:0] out_digits,
   output logic                out_none
);
   import ngdp_pkg::*;

   localparam int DW = 4 * DIGITS;
   localparam int KW = $clog2(DIGITS);

   logic adv1, adv2, adv3;
   logic v1_ff, v2_ff, v3_ff;

   // Stage 1: pivot position, the lowest digit index k that is smaller
   // than its less significant neighbor and lies inside the number.
   logic [DW-1:0] dig1_ff;
   logic [KW-1:0] k1_ff, k1_in;
   logic          found1_ff, found1_in;
   logic          long1_ff;

   always_comb begin
      logic              above;
      logic [DIGITS-1:0] rise;
      above = 1'b0;
      rise  = '0;
      k1_in = '0;
      for (int j = DIGITS - 1; j >= 1; j--) begin
         above   = above || (in_digits[4*j +: 4] != 4'd0);
         rise[j] = above && (in_digits[4*j +: 4] < in_digits[4*(j-1) +: 4]);
      end
      for (int j = DIGITS - 1; j >= 1; j--) begin
         if (rise[j]) begin
            k1_in = KW'(j);
         end
      end
      found1_in = |rise;
   end

   // Stage 2: pivot digit and the smallest suffix digit above it.
   logic [DW-1:0] dig2_ff;
   logic [KW-1:0] k2_ff;
   logic [KW-1:0] m2_ff, m2_in;
   logic [3:0]    pv2_ff, pv2_in;
   logic          none2_ff;

   always_comb begin
      logic [DW-1:0] shifted;
      shifted = dig1_ff >> {k1_ff, 2'b00};
      pv2_in  = shifted[3:0];
      m2_in   = '0;
      for (int j = DIGITS - 1; j >= 0; j--) begin
         if ((KW'(j) < k1_ff) && (dig1_ff[4*j +: 4] > pv2_in)) begin
            m2_in = KW'(j);
         end
      end
   end

   // Stage 3: reversed suffix with the pivot swapped in.
   logic [DW-1:0] dig3_ff, dig3_in;
   logic          none3_ff;

   always_comb begin
      logic [DW-1:0] rev;
      logic [DW-1:0] tail;
      logic [DW-1:0] from_m;
      logic [KW:0]   sh;
      logic [KW-1:0] pos;
      for (int j = 0; j < DIGITS; j++) begin
         rev[4*j +: 4] = dig2_ff[4*(DIGITS-1-j) +: 4];
      end
      sh     = (KW+1)'(DIGITS) - {1'b0, k2_ff};
      tail   = rev >> {sh, 2'b00};
      from_m = dig2_ff >> {m2_ff, 2'b00};
      pos    = k2_ff - KW'(1) - m2_ff;
      for (int j = 0; j < DIGITS; j++) begin
         if (KW'(j) > k2_ff) begin
            dig3_in[4*j +: 4] = dig2_ff[4*j +: 4];
         end else if (KW'(j) == k2_ff) begin
            dig3_in[4*j +: 4] = from_m[3:0];
         end else if (KW'(j) == pos) begin
            dig3_in[4*j +: 4] = pv2_ff;
         end else begin
            dig3_in[4*j +: 4] = tail[4*j +: 4];
         end
      end
   end

   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         dig1_ff   <= in_digits;
         k1_ff     <= k1_in;
         found1_ff <= found1_in;
         long1_ff  <= in_too_long;
      end
      if (adv2) begin
         dig2_ff  <= dig1_ff;
         k2_ff    <= k1_ff;
         m2_ff    <= m2_in;
         pv2_ff   <= pv2_in;
         none2_ff <= !found1_ff || long1_ff;
      end
      if (adv3) begin
         dig3_ff  <= dig3_in;
         none3_ff <= none2_ff;
      end
   end

   assign in_ready   = adv1;
   assign out_valid  = v3_ff;
   assign out_digits = dig3_ff;
   assign out_none   = none3_ff;

endmodule

`default_nettype wire

// File: design/ngdp_pack.sv
// BCD to binary recombination with range check and result register, three stages.
`default_nettype none

module ngdp_pack #(
   parameter int DIGITS = ngdp_pkg::NUM_DIGITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [4*DIGITS-1:0]              in_digits,
   input  logic                             in_none,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [ngdp_pkg::RESULT_BITS-1:0] out_value,
   output logic                             out_has_next
);
   import ngdp_pkg::*;

   localparam int PW = 17;
   localparam int AW = 2 * PW + 1;

   logic adv1, adv2, adv3;
   logic v1_ff, v2_ff, v3_ff;

   // Stage 1: low and high partial words, each a sum of constant-weighted digits.
   logic [PW-1:0] lo1_ff, lo1_in, hi1_ff, hi1_in;
   logic          none1_ff;

   always_comb begin
      lo1_in = '0;
      hi1_in = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (i < LO_DIGITS) begin
            lo1_in = lo1_in + PW'(in_digits[4*i +: 4]) * PW'(pow10(i));
         end else begin
            hi1_in = hi1_in + PW'(in_digits[4*i +: 4]) * PW'(pow10(i - LO_DIGITS));
         end
      end
   end

   // Stage 2: full binary value.
   logic [AW-1:0] acc2_ff, acc2_in;
   logic          none2_ff;

   assign acc2_in = AW'(hi1_ff) * AW'(pow10(LO_DIGITS)) + AW'(lo1_ff);

   // Stage 3: range check and the registered result.
   logic [RESULT_BITS-1:0] value3_ff, value3_in;
   logic                   has3_ff, has3_in;

   assign has3_in   = !none2_ff && (acc2_ff <= AW'(INT_MAX));
   assign value3_in = has3_in ? acc2_ff[RESULT_BITS-1:0] : NONE_VALUE;

   assign adv3 = !v3_ff || out_ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv1) begin
            v1_ff <= in_valid;
         end
         if (adv2) begin
            v2_ff <= v1_ff;
         end
         if (adv3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         lo1_ff   <= lo1_in;
         hi1_ff   <= hi1_in;
         none1_ff <= in_none;
      end
      if (adv2) begin
         acc2_ff  <= acc2_in;
         none2_ff <= none1_ff;
      end
      if (adv3) begin
         value3_ff <= value3_in;
         has3_ff   <= has3_in;
      end
   end

   assign in_ready     = adv1;
   assign out_valid    = v3_ff;
   assign out_value    = value3_ff;
   assign out_has_next = has3_ff;

endmodule

`default_nettype wire

// File: design/next_greater_digit_permutation_unit.sv
// Top level of the next greater digit permutation unit.
//
// The unit takes a positive integer on the req_ stream and returns, on the
// rsp_ stream, the smallest larger number made of the same decimal digits.
// When no such number exists, or when it does not fit in 31 bits, the
// result is all ones (-1) and the has_next flag on rsp_tuser is low.
// Each request transaction produces exactly one response transaction, in
// order.
//
// The datapath is a ten-stage pipeline: four stages of binary to BCD
// conversion (eight double-dabble steps per stage, seven in the last), three
// stages of pivot search and suffix rearrangement, and three stages of
// recombination, range check and result register. Unless the receiver
// stalls the pipeline, a request can be taken every cycle.
//
// Each stage holds its own valid bit and advances whenever it is empty or
// the stage after it advances. When the receiver stalls, the result waits
// in the output register and empty stages upstream keep filling, so
// requests are still taken until the pipeline is full. Synchronous reset
// clears all valid bits; no response is pending after reset.
`default_nettype none

module next_greater_digit_permutation_unit #(
   parameter int MAX_DIGITS = ngdp_pkg::DEFAULT_MAX_DIGITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [30:0] number_in, [31] zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] next_value
   output logic        rsp_tuser    // [0] has_next
);
   import ngdp_pkg::*;

   // Digit slots actually built: a 31-bit operand never needs more than ten.
   localparam int Slots = (MAX_DIGITS < NUM_DIGITS) ? MAX_DIGITS : NUM_DIGITS;

   logic                 bcd_valid, bcd_ready, bcd_too_long;
   logic [4*Slots-1:0]   bcd_digits;
   logic                 perm_valid, perm_ready, perm_none;
   logic [4*Slots-1:0]   perm_digits;

   ngdp_bcd #(
      .DIGITS(Slots)
   ) u_bcd (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_number   (req_tdata[NUM_BITS-1:0]),
      .out_valid   (bcd_valid),
      .out_ready   (bcd_ready),
      .out_digits  (bcd_digits),
      .out_too_long(bcd_too_long)
   );

   ngdp_permute #(
      .DIGITS(Slots)
   ) u_permute (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (bcd_valid),
      .in_ready   (bcd_ready),
      .in_digits  (bcd_digits),
      .in_too_long(bcd_too_long),
      .out_valid  (perm_valid),
      .out_ready  (perm_ready),
      .out_digits (perm_digits),
      .out_none   (perm_none)
   );

   ngdp_pack #(
      .DIGITS(Slots)
   ) u_pack (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (perm_valid),
      .in_ready    (perm_ready),
      .in_digits   (perm_digits),
      .in_none     (perm_none),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_value   (rsp_tdata),
      .out_has_next(rsp_tuser)
   );

endmodule

`default_nettype wire

// File: design/ngdp_checker.sv
// Port-level checker for the next greater digit permutation unit and its bind.
`default_nettype none

module ngdp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);
   import ngdp_pkg::*;

   // A stalled response transaction keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response payload changed while stalled");

   // Without a permutation the value must be the all-ones marker.
   a_none_value: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == NONE_VALUE)
      else $error("no-permutation response carries a value other than -1");

   // A valid permutation always fits in 31 bits.
   a_has_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata <= INT_MAX)
      else $error("permutation response exceeds the 31-bit range");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response pending right after reset");

endmodule

bind next_greater_digit_permutation_unit ngdp_checker u_ngdp_checker (.*);

`default_nettype wire

// File: tb/tb_next_greater_digit_permutation_unit.sv
// Self-checking testbench for the next greater digit permutation unit.
module tb_next_greater_digit_permutation_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import ngdp_pkg::*;

   // The unit is built with its default digit capacity, so the predictor uses the same.
   localparam int MAX_DIGITS = DEFAULT_MAX_DIGITS;

   // Response stall length for the backpressure test. It is far longer than
   // the pipeline depth, so the input side has to stall.
   localparam int HOLDOFF_CYCLES = 300;

   // The run is aborted after this many cycles in which no transaction completes.
   localparam int WATCHDOG_LIMIT = 2000;

   // Cycles to wait after the last response so that stray responses are caught.
   localparam int SETTLE_CYCLES = 20;

   // One expected response, together with the number that produced it so
   // that mismatch messages can name the request.
   typedef struct packed {
      logic [30:0] number;
      logic [31:0] next_value;
      logic        has_next;
   } permutation_type;

   // Kinds of random numbers in the random stimulus.
   typedef enum int {
      MIX_UNIFORM,
      MIX_FEW_DIGITS,
      MIX_DESCENDING,
      MIX_NEAR_LIMIT,
      MIX_SHORT
   } number_mix_type;

   // All inputs of the unit hold known values from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [30:0] number_in, [31] zero fill
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // [31:0] next_value
   logic        rsp_tuser;        // [0] has_next

   // The stimulus process fills the request queue. The driver consumes it.
   // The driver pushes one prediction into the expectation queue for each
   // accepted request transaction, and the monitor pops them in order.
   logic [30:0]     pending_numbers[$];
   permutation_type expected_permutations[$];

   // Idling knobs and holdoff requests are written by the stimulus process
   // on the falling edge only. Clocked processes read them on the rising edge.
   int sender_idle_pct   = 0;
   int receiver_idle_pct = 0;
   int holdoff_requests  = 0;

   int holdoff_left     = 0;
   int holdoffs_started = 0;
   int stall_cycles     = 0;

   int error_count       = 0;
   int numbers_sent      = 0;
   int responses_checked = 0;
   int larger_found      = 0;
   int stalled_offers    = 0;
   int directed_count    = 0;

   next_greater_digit_permutation_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // This computes the smallest larger number that uses the same decimal
   // digits. It returns all ones and a low flag when there is none, when the
   // result does not fit in 31 bits, or when the input has too many digits.
   function automatic permutation_type next_digit_permutation(input logic [30:0] number);
      logic [3:0]      lsd_first[NUM_DIGITS];
      logic [3:0]      msd_first[NUM_DIGITS];
      logic [3:0]      held;
      logic [63:0]     rest;
      logic [63:0]     value;
      int              count;
      int              pivot;
      int              lo;
      int              hi;
      permutation_type result;
      result.number     = number;
      result.next_value = NONE_VALUE;
      result.has_next   = 1'b0;
      rest  = {33'd0, number};
      count = 0;
      while (rest != 0) begin
         lsd_first[count] = 4'(rest % 64'd10);
         rest = rest / 64'd10;
         count++;
      end
      // Zero has no digit to move. An input that is too long is rejected as a whole.
      if (count == 0 || count > MAX_DIGITS) begin
         return result;
      end
      for (int i = 0; i < count; i++) begin
         msd_first[i] = lsd_first[count - 1 - i];
      end
      // The pivot is the first digit, counted from the right, that is smaller
      // than the digit to its right.
      pivot = count - 1;
      while (pivot > 0 && !(msd_first[pivot - 1] < msd_first[pivot])) begin
         pivot--;
      end
      if (pivot == 0) begin
         return result;
      end
      // The suffix is non-increasing. Reversing it gives its smallest order.
      lo = pivot;
      hi = count - 1;
      while (lo < hi) begin
         held           = msd_first[lo];
         msd_first[lo]  = msd_first[hi];
         msd_first[hi]  = held;
         lo++;
         hi--;
      end
      for (int i = pivot; i < count; i++) begin
         if (msd_first[i] > msd_first[pivot - 1]) begin
            held                 = msd_first[i];
            msd_first[i]         = msd_first[pivot - 1];
            msd_first[pivot - 1] = held;
            break;
         end
      end
      value = '0;
      for (int i = 0; i < count; i++) begin
         value = value * 64'd10 + 64'(msd_first[i]);
      end
      if (value > {32'd0, INT_MAX}) begin
         return result;
      end
      result.next_value = value[31:0];
      result.has_next   = 1'b1;
      return result;
   endfunction

   // A digit string that exceeds the input range loses its leading digit.
   // The result is then below 10^9.
   function automatic logic [30:0] digits_to_number(input int digits[$]);
      logic [63:0] value;
      value = '0;
      foreach (digits[i]) begin
         value = value * 64'd10 + 64'(digits[i]);
      end
      if (value > {32'd0, INT_MAX}) begin
         value = value % 64'd1000000000;
      end
      return value[30:0];
   endfunction

   // The random numbers are a mix of kinds. Uniform values toggle every
   // input bit. Values from a narrow digit alphabet repeat digits, which
   // stresses the search for a larger digit. Numbers with descending digits
   // have no pivot. Values close to the 31-bit limit often overflow.
   function automatic logic [30:0] random_number();
      int digits[$];
      int length;
      int base;
      logic [30:0] number;
      number = '0;
      case (number_mix_type'($urandom_range(4)))
         MIX_UNIFORM: begin
            number = 31'($urandom());
         end
         MIX_FEW_DIGITS: begin
            length = $urandom_range(1, NUM_DIGITS);
            base   = $urandom_range(9);
            repeat (length) digits.push_back($urandom_range(base, (base > 7) ? 9 : base + 2));
            number = digits_to_number(digits);
         end
         MIX_DESCENDING: begin
            length = $urandom_range(1, NUM_DIGITS);
            repeat (length) digits.push_back($urandom_range(9));
            digits.rsort();
            number = digits_to_number(digits);
         end
         MIX_NEAR_LIMIT: begin
            number = 31'($urandom_range(32'h7FFF_FFFF, 32'd2000000000));
         end
         default: begin
            number = 31'($urandom_range(9999));
         end
      endcase
      return number;
   endfunction

   task automatic queue_random_numbers(input int count);
      repeat (count) pending_numbers.push_back(random_number());
   endtask

   // The sender stops offering new work until every expected response has arrived.
   task automatic wait_for_drain();
      while (pending_numbers.size() != 0 || req_tvalid || expected_permutations.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic report_mismatch(input string message);
      $display("MISMATCH at %0t ns: %s", $realtime, message);
      error_count++;
   endtask

   // The request driver predicts each accepted transaction from the value
   // that was on the bus at the edge. After that it either holds the current
   // offer, presents the next number, or idles. Only one nonblocking
   // assignment is made to each signal per edge. This keeps a valid that stays
   // high from toggling within the time step.
   always @(posedge clock) begin : request_driver
      logic [30:0] number;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_permutations.push_back(next_digit_permutation(req_tdata[30:0]));
            numbers_sent++;
         end else if (req_tvalid) begin
            stalled_offers++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_numbers.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               number = pending_numbers.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {1'b0, number};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // The response side accepts at random. When a holdoff is requested, it
   // deasserts ready for a long stretch that this process counts by itself.
   always @(posedge clock) begin : response_receiver
      if (reset) begin
         rsp_tready       <= 1'b0;
         holdoff_left     <= 0;
         holdoffs_started <= 0;
      end else if (holdoff_left != 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoffs_started != holdoff_requests) begin
         rsp_tready       <= 1'b0;
         holdoff_left     <= HOLDOFF_CYCLES - 1;
         holdoffs_started <= holdoffs_started + 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // Each response transaction is checked field by field against the oldest prediction.
   always @(posedge clock) begin : response_monitor
      permutation_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_permutations.size() == 0) begin
            report_mismatch($sformatf("response %0d/%0b with no request outstanding",
                                      $signed(rsp_tdata), rsp_tuser));
         end else begin
            want = expected_permutations.pop_front();
            if (rsp_tdata !== want.next_value) begin
               report_mismatch($sformatf("number %0d: next_value %0d, expected %0d",
                                         want.number, $signed(rsp_tdata),
                                         $signed(want.next_value)));
            end
            if (rsp_tuser !== want.has_next) begin
               report_mismatch($sformatf("number %0d: has_next %b, expected %b",
                                         want.number, rsp_tuser, want.has_next));
            end
            responses_checked++;
            if (want.has_next) begin
               larger_found++;
            end
         end
      end
   end

   // The watchdog ends the run if no transaction completes on either side for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no transaction for %0d cycles, %0d responses outstanding",
                  stall_cycles, expected_permutations.size());
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Phase one: the sender idles rarely and the receiver idles most of the
      // time. The directed numbers go first. They cover zero, single digits,
      // numbers with no pivot, repeated digits, the largest input, a result
      // that lands exactly on the 31-bit limit, and results that overflow it.
      sender_idle_pct   = 8;
      receiver_idle_pct = 83;
      pending_numbers = {31'd0, 31'd1, 31'd9, 31'd10, 31'd11, 31'd12, 31'd21, 31'd115,
                         31'd2013, 31'd534976, 31'd987654321, 31'd1000000000,
                         31'd1111111111, 31'd1234567890, 31'd1463847412,
                         31'd1073741824, 31'd1999999999, 31'd2147483476,
                         31'd2147483646, 31'd2147483647};
      directed_count = pending_numbers.size();
      queue_random_numbers(430);
      wait_for_drain();

      // Phase two is the reverse pattern: the sender idles most of the time.
      sender_idle_pct   = 83;
      receiver_idle_pct = 8;
      queue_random_numbers(430);
      wait_for_drain();

      // Phase three has no idling on either side. One long response stall
      // fills the pipeline and forces backpressure onto the request side.
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      queue_random_numbers(220);
      holdoff_requests++;
      wait_for_drain();
      queue_random_numbers(220);
      wait_for_drain();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_permutations.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", expected_permutations.size()));
      end

      $display("Checked %0d of %0d numbers (%0d directed), %0d with a larger one.",
               responses_checked, numbers_sent, directed_count, larger_found);
      $display("Covered three idling phases and a long stall; %0d offers saw backpressure.",
               stalled_offers);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
